### rtl/lss_pkg.sv
// shared types, action and status codes for the key/value lifo stack
package lss_pkg;

   localparam int DEPTH_DEFAULT     = 256;
   localparam int MAX_BURST_DEFAULT = 64;

   localparam int ACTION_W = 3;
   localparam int STATUS_W = 3;
   localparam int DATA_W   = 32;
   localparam int COUNT_W  = 9;

   localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

   localparam logic [ACTION_W-1:0] ACT_PUSH        = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PUSH_UNIQUE = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_POP         = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_MULTI_POP   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_PEEK        = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_SEARCH      = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_REVERSE     = 3'd6;
   localparam logic [ACTION_W-1:0] ACT_CLEAR       = 3'd7;

   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] ST_DUP      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

   typedef struct packed {
      logic [ACTION_W-1:0]      action;
      logic signed [DATA_W-1:0] key;
      logic [DATA_W-1:0]        value;
      logic [COUNT_W-1:0]       count;
   } cmd_type;

endpackage

### rtl/lifo_stack_with_search.sv
// top level: key/value lifo stack with search, reverse and burst pop
// push, clear, refused/empty: 1 beat per cycle unless rsp stalls; result is registered
// pop, peek, push_unique: wait in S_TOP for the registered top-of-stack read
// multi_pop: one result beat per entry; search: scans up from entry 0 to the first match
// reverse: swaps pairs via S_REVRD/S_REVWR, one write each on the single write port
// reset empties the stack and sets the capacity to 256; memory is not cleared
module lifo_stack_with_search import lss_pkg::*; #(
   parameter int DEPTH     = DEPTH_DEFAULT,
   parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic signed [DATA_W-1:0]  req_entry_key,
   input  logic [DATA_W-1:0]         req_entry_value,
   input  logic [COUNT_W-1:0]        req_pop_count,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [DATA_W-1:0]  rsp_out_key,
   output logic [DATA_W-1:0]         rsp_out_value,
   output logic [COUNT_W-1:0]        rsp_position,
   output logic [COUNT_W-1:0]        rsp_fill_count,
   output logic                      rsp_last,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [COUNT_W-1:0]        csr_wdata
);

   logic [COUNT_W-1:0] cap_ff, cap_in;

   logic    fq_valid, fq_ready;
   cmd_type fq_cmd;
   logic    qb_valid, qb_ready;
   cmd_type qb_cmd;

   assign csr_ready = 1'b1;
   assign cap_in    = (csr_valid && csr_ready) ? csr_wdata : cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= CAP_RESET;
      end else begin
         cap_ff <= cap_in;
      end
   end

   lss_front #(
      .MAX_BURST (MAX_BURST)
   ) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_entry_key   (req_entry_key),
      .req_entry_value (req_entry_value),
      .req_pop_count   (req_pop_count),
      .q_valid         (fq_valid),
      .q_ready         (fq_ready),
      .q_cmd           (fq_cmd)
   );

   lss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_cmd)
   );

   lss_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .cap            (cap_ff),
      .q_valid        (qb_valid),
      .q_ready        (qb_ready),
      .q_cmd          (qb_cmd),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_out_key    (rsp_out_key),
      .rsp_out_value  (rsp_out_value),
      .rsp_position   (rsp_position),
      .rsp_fill_count (rsp_fill_count),
      .rsp_last       (rsp_last)
   );

endmodule

### rtl/lss_front.sv
// request intake: decodes the action and clamps the burst count
module lss_front import lss_pkg::*; #(
   parameter int MAX_BURST = MAX_BURST_DEFAULT
) (
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic signed [DATA_W-1:0]  req_entry_key,
   input  logic [DATA_W-1:0]         req_entry_value,
   input  logic [COUNT_W-1:0]        req_pop_count,
   output logic                      q_valid,
   input  logic                      q_ready,
   output cmd_type                   q_cmd
);

   localparam logic [COUNT_W-1:0] BURST = COUNT_W'(MAX_BURST);

   logic key_used;

   assign req_ready = q_ready;
   assign q_valid   = req_valid;

   always_comb begin
      key_used = 1'b0;
      unique case (req_action) inside
         ACT_PUSH, ACT_PUSH_UNIQUE, ACT_SEARCH: key_used = 1'b1;
         default: key_used = 1'b0;
      endcase
   end

   always_comb begin
      q_cmd.action = req_action;
      q_cmd.key    = key_used ? req_entry_key : '0;
      q_cmd.value  = key_used ? req_entry_value : '0;
      q_cmd.count  = '0;
      if (req_action == ACT_MULTI_POP) begin
         q_cmd.count = (req_pop_count > BURST) ? BURST : req_pop_count;
      end
   end

endmodule

### rtl/lss_queue.sv
// two-entry command queue between intake and executor
module lss_queue import lss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/lss_back.sv
// executor: stack memory, sequencer and result register
module lss_back import lss_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [COUNT_W-1:0]        cap,
   input  logic                      q_valid,
   output logic                      q_ready,
   input  cmd_type                   q_cmd,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [STATUS_W-1:0]       rsp_status,
   output logic signed [DATA_W-1:0]  rsp_out_key,
   output logic [DATA_W-1:0]         rsp_out_value,
   output logic [COUNT_W-1:0]        rsp_position,
   output logic [COUNT_W-1:0]        rsp_fill_count,
   output logic                      rsp_last
);

   localparam int STORE = (DEPTH < 511) ? DEPTH : 511;
   localparam int AW    = $clog2(STORE);
   localparam logic [COUNT_W-1:0] STORE_N = COUNT_W'(STORE);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_TOP    = 3'd1;
   localparam logic [2:0] S_SRCH   = 3'd2;
   localparam logic [2:0] S_REVRD  = 3'd3;
   localparam logic [2:0] S_REVWR  = 3'd4;
   localparam logic [2:0] S_REVEND = 3'd5;

   logic signed [DATA_W-1:0] key_mem_ff [STORE];
   logic [DATA_W-1:0]        val_mem_ff [STORE];

   logic [2:0]               state_ff, state_in;
   logic [COUNT_W-1:0]       fill_ff, fill_in;
   cmd_type                  cmd_ff, cmd_in;
   logic [COUNT_W-1:0]       rem_ff, rem_in;
   logic [COUNT_W-1:0]       idx_ff, idx_in;
   logic [COUNT_W-1:0]       lo_ff, lo_in;
   logic [COUNT_W-1:0]       hi_ff, hi_in;

   logic signed [DATA_W-1:0] rd_key_a_ff, rd_key_b_ff;
   logic [DATA_W-1:0]        rd_val_a_ff, rd_val_b_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [DATA_W-1:0] rsp_key_ff, rsp_key_in;
   logic [DATA_W-1:0]        rsp_val_ff, rsp_val_in;
   logic [COUNT_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [COUNT_W-1:0]       rsp_fill_ff, rsp_fill_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [DATA_W-1:0] wr_key;
   logic [DATA_W-1:0]        wr_val;
   logic                     rd_en_a, rd_en_b;
   logic [AW-1:0]            rd_addr_a, rd_addr_b;

   logic                     emit, out_free, full, empty, match;
   logic [COUNT_W-1:0]       lim, fill_m1, fill_m2, idx_p1, lo_p1, hi_m1;

   assign lim      = (cap > STORE_N) ? STORE_N : cap;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign full     = (fill_ff >= lim);
   assign empty    = (fill_ff == '0);
   assign fill_m1  = fill_ff - 1'b1;
   assign fill_m2  = fill_ff - 2'd2;
   assign idx_p1   = idx_ff + 1'b1;
   assign lo_p1    = lo_ff + 1'b1;
   assign hi_m1    = hi_ff - 1'b1;
   assign match    = (rd_key_a_ff == cmd_ff.key) && (rd_val_a_ff == cmd_ff.value);

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      cmd_in        = cmd_ff;
      rem_in        = rem_ff;
      idx_in        = idx_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      q_ready       = 1'b0;
      emit          = 1'b0;
      rsp_status_in = ST_OK;
      rsp_key_in    = '0;
      rsp_val_in    = '0;
      rsp_pos_in    = '0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[AW-1:0];
      wr_key        = q_cmd.key;
      wr_val        = q_cmd.value;
      rd_en_a       = 1'b0;
      rd_en_b       = 1'b0;
      rd_addr_a     = fill_m1[AW-1:0];
      rd_addr_b     = fill_m1[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               cmd_in = q_cmd;
               unique case (q_cmd.action) inside
                  ACT_PUSH, ACT_PUSH_UNIQUE: begin
                     if (full || empty || q_cmd.action == ACT_PUSH) begin
                        if (out_free) begin
                           q_ready = 1'b1;
                           emit    = 1'b1;
                           if (full) begin
                              rsp_status_in = ST_FULL;
                           end else begin
                              wr_en   = 1'b1;
                              fill_in = fill_ff + 1'b1;
                           end
                        end
                     end else begin
                        q_ready  = 1'b1;
                        rd_en_a  = 1'b1;
                        state_in = S_TOP;
                     end
                  end
                  ACT_POP, ACT_PEEK, ACT_MULTI_POP: begin
                     if (empty || q_cmd.action == ACT_MULTI_POP && q_cmd.count == '0) begin
                        if (out_free) begin
                           q_ready       = 1'b1;
                           emit          = 1'b1;
                           rsp_status_in = empty ? ST_EMPTY : ST_OK;
                        end
                     end else begin
                        q_ready  = 1'b1;
                        rd_en_a  = 1'b1;
                        rem_in   = (q_cmd.action != ACT_MULTI_POP) ? COUNT_W'(1) :
                                   (q_cmd.count > fill_ff) ? fill_ff : q_cmd.count;
                        state_in = S_TOP;
                     end
                  end
                  ACT_SEARCH: begin
                     if (empty) begin
                        if (out_free) begin
                           q_ready       = 1'b1;
                           emit          = 1'b1;
                           rsp_status_in = ST_NOTFOUND;
                        end
                     end else begin
                        q_ready   = 1'b1;
                        rd_en_a   = 1'b1;
                        rd_addr_a = '0;
                        idx_in    = '0;
                        state_in  = S_SRCH;
                     end
                  end
                  ACT_REVERSE: begin
                     if (fill_ff <= COUNT_W'(1)) begin
                        if (out_free) begin
                           q_ready = 1'b1;
                           emit    = 1'b1;
                        end
                     end else begin
                        q_ready   = 1'b1;
                        rd_en_a   = 1'b1;
                        rd_en_b   = 1'b1;
                        rd_addr_a = '0;
                        lo_in     = '0;
                        hi_in     = fill_m1;
                        state_in  = S_REVRD;
                     end
                  end
                  default: begin
                     if (out_free) begin
                        q_ready = 1'b1;
                        emit    = 1'b1;
                        fill_in = '0;
                     end
                  end
               endcase
            end
         end
         S_TOP: begin
            wr_key = cmd_ff.key;
            wr_val = cmd_ff.value;
            if (out_free) begin
               emit = 1'b1;
               unique case (cmd_ff.action) inside
                  ACT_PUSH_UNIQUE: begin
                     state_in = S_IDLE;
                     if (rd_val_a_ff == cmd_ff.value) begin
                        rsp_status_in = ST_DUP;
                     end else begin
                        wr_en   = 1'b1;
                        fill_in = fill_ff + 1'b1;
                     end
                  end
                  ACT_PEEK: begin
                     state_in   = S_IDLE;
                     rsp_key_in = rd_key_a_ff;
                     rsp_val_in = rd_val_a_ff;
                  end
                  default: begin
                     rsp_key_in  = rd_key_a_ff;
                     rsp_val_in  = rd_val_a_ff;
                     fill_in     = fill_m1;
                     rem_in      = rem_ff - 1'b1;
                     rsp_last_in = (rem_ff == COUNT_W'(1));
                     if (rem_ff == COUNT_W'(1)) begin
                        state_in = S_IDLE;
                     end else begin
                        rd_en_a   = 1'b1;
                        rd_addr_a = fill_m2[AW-1:0];
                     end
                  end
               endcase
            end
         end
         S_SRCH: begin
            if (match || idx_p1 == fill_ff) begin
               if (out_free) begin
                  emit          = 1'b1;
                  rsp_status_in = match ? ST_OK : ST_NOTFOUND;
                  rsp_pos_in    = match ? idx_p1 : '0;
                  state_in      = S_IDLE;
               end
            end else begin
               idx_in    = idx_p1;
               rd_en_a   = 1'b1;
               rd_addr_a = idx_p1[AW-1:0];
            end
         end
         S_REVRD: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_key   = rd_key_b_ff;
            wr_val   = rd_val_b_ff;
            state_in = S_REVWR;
         end
         S_REVWR: begin
            wr_en   = 1'b1;
            wr_addr = hi_ff[AW-1:0];
            wr_key  = rd_key_a_ff;
            wr_val  = rd_val_a_ff;
            lo_in   = lo_p1;
            hi_in   = hi_m1;
            if (lo_p1 < hi_m1) begin
               rd_en_a   = 1'b1;
               rd_en_b   = 1'b1;
               rd_addr_a = lo_p1[AW-1:0];
               rd_addr_b = hi_m1[AW-1:0];
               state_in  = S_REVRD;
            end else begin
               state_in = S_REVEND;
            end
         end
         S_REVEND: begin
            if (out_free) begin
               emit     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_fill_in  = fill_in;
      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rem_ff <= rem_in;
      idx_ff <= idx_in;
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      if (emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_key_ff    <= rsp_key_in;
         rsp_val_ff    <= rsp_val_in;
         rsp_pos_ff    <= rsp_pos_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem_ff[wr_addr] <= wr_key;
         val_mem_ff[wr_addr] <= wr_val;
      end
      if (rd_en_a) begin
         rd_key_a_ff <= key_mem_ff[rd_addr_a];
         rd_val_a_ff <= val_mem_ff[rd_addr_a];
      end
      if (rd_en_b) begin
         rd_key_b_ff <= key_mem_ff[rd_addr_b];
         rd_val_b_ff <= val_mem_ff[rd_addr_b];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_out_key    = rsp_key_ff;
   assign rsp_out_value  = rsp_val_ff;
   assign rsp_position   = rsp_pos_ff;
   assign rsp_fill_count = rsp_fill_ff;
   assign rsp_last       = rsp_last_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= STORE_N)
      else $error("fill beyond storage");

   a_burst_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TOP && cmd_ff.action == ACT_MULTI_POP)
      |-> (rem_ff != '0 && rem_ff <= fill_ff))
      else $error("multi-pop count out of range");

   a_search_idx: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SRCH |-> idx_ff < fill_ff)
      else $error("search index past top");

   a_rev_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_REVRD || state_ff == S_REVWR) |-> (lo_ff < hi_ff && hi_ff < fill_ff))
      else $error("reverse pointers crossed");

endmodule

### verif/lifo_stack_with_search_test.sv
// self-checking testbench for the key/value lifo stack with search, reverse and burst pop
module lifo_stack_with_search_test import lss_pkg::*;;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;
   localparam int BURST       = MAX_BURST_DEFAULT;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   key;
      logic [DATA_W-1:0]   value;
      logic [COUNT_W-1:0]  position;
      logic [COUNT_W-1:0]  fill;
      logic                last;
   } stack_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [ACTION_W-1:0]      req_action = ACT_PUSH;
   logic signed [DATA_W-1:0] req_entry_key = '0;
   logic [DATA_W-1:0]        req_entry_value = '0;
   logic [COUNT_W-1:0]       req_pop_count = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic signed [DATA_W-1:0] rsp_out_key;
   logic [DATA_W-1:0]        rsp_out_value;
   logic [COUNT_W-1:0]       rsp_position;
   logic [COUNT_W-1:0]       rsp_fill_count;
   logic                     rsp_last;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [COUNT_W-1:0]       csr_wdata = '0;

   cmd_type          req_backlog[$];
   stack_result_type owed_results[$];
   logic             req_taken = 1'b0;
   int               items_queued = 0;
   int               items_answered = 0;
   int               csr_beats = 0;
   int               errors = 0;
   int               sender_idle_pct = 0;
   int               receiver_stall_pct = 0;

   logic [DATA_W-1:0]  model_keys[STACK_DEPTH];
   logic [DATA_W-1:0]  model_values[STACK_DEPTH];
   int                 model_fill = 0;
   logic [COUNT_W-1:0] model_capacity = CAP_RESET;

   logic [DATA_W-1:0] key_pool[4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
   logic [DATA_W-1:0] value_pool[4] = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000};

   lifo_stack_with_search dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_entry_key   (req_entry_key),
      .req_entry_value (req_entry_value),
      .req_pop_count   (req_pop_count),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_value   (rsp_out_value),
      .rsp_position    (rsp_position),
      .rsp_fill_count  (rsp_fill_count),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_wdata       (csr_wdata)
   );

   always #5 clock = ~clock;

   function void owe_result(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] key,
                            logic [DATA_W-1:0] value, int position, bit last);
      stack_result_type r;
      r.status   = status;
      r.key      = key;
      r.value    = value;
      r.position = position[COUNT_W-1:0];
      r.fill     = model_fill[COUNT_W-1:0];
      r.last     = last;
      owed_results.push_back(r);
   endfunction

   function logic [STATUS_W-1:0] stash_entry(logic [DATA_W-1:0] key, logic [DATA_W-1:0] value,
                                             int limit);
      if (model_fill >= limit) return ST_FULL;
      model_keys[model_fill]   = key;
      model_values[model_fill] = value;
      model_fill++;
      return ST_OK;
   endfunction

   task automatic compute_stack_results(input cmd_type c);
      int                limit;
      int                n;
      int                i;
      int                j;
      bit                found;
      logic [DATA_W-1:0] t;
      limit = (model_capacity > STACK_DEPTH) ? STACK_DEPTH : int'(model_capacity);
      case (c.action)
         ACT_PUSH: begin
            owe_result(stash_entry(c.key, c.value, limit), '0, '0, 0, 1'b1);
         end
         ACT_PUSH_UNIQUE: begin
            // full takes precedence over the duplicate check
            if (model_fill >= limit) begin
               owe_result(ST_FULL, '0, '0, 0, 1'b1);
            end else if (model_fill > 0 && model_values[model_fill-1] == c.value) begin
               owe_result(ST_DUP, '0, '0, 0, 1'b1);
            end else begin
               owe_result(stash_entry(c.key, c.value, limit), '0, '0, 0, 1'b1);
            end
         end
         ACT_POP: begin
            if (model_fill == 0) begin
               owe_result(ST_EMPTY, '0, '0, 0, 1'b1);
            end else begin
               model_fill--;
               owe_result(ST_OK, model_keys[model_fill], model_values[model_fill], 0, 1'b1);
            end
         end
         ACT_MULTI_POP: begin
            if (model_fill == 0) begin
               owe_result(ST_EMPTY, '0, '0, 0, 1'b1);
            end else if (c.count == 0) begin
               owe_result(ST_OK, '0, '0, 0, 1'b1);
            end else begin
               n = c.count;
               if (n > model_fill) n = model_fill;
               if (n > BURST) n = BURST;
               for (i = 0; i < n; i++) begin
                  model_fill--;
                  owe_result(ST_OK, model_keys[model_fill], model_values[model_fill], 0,
                             i == n - 1);
               end
            end
         end
         ACT_PEEK: begin
            if (model_fill == 0) begin
               owe_result(ST_EMPTY, '0, '0, 0, 1'b1);
            end else begin
               owe_result(ST_OK, model_keys[model_fill-1], model_values[model_fill-1], 0, 1'b1);
            end
         end
         ACT_SEARCH: begin
            // lowest matching position wins
            found = 1'b0;
            for (i = 0; i < model_fill; i++) begin
               if (!found && model_keys[i] == c.key && model_values[i] == c.value) begin
                  owe_result(ST_OK, '0, '0, i + 1, 1'b1);
                  found = 1'b1;
               end
            end
            if (!found) owe_result(ST_NOTFOUND, '0, '0, 0, 1'b1);
         end
         ACT_REVERSE: begin
            i = 0;
            j = model_fill - 1;
            while (i < j) begin
               t = model_keys[i];   model_keys[i] = model_keys[j];     model_keys[j] = t;
               t = model_values[i]; model_values[i] = model_values[j]; model_values[j] = t;
               i++;
               j--;
            end
            owe_result(ST_OK, '0, '0, 0, 1'b1);
         end
         default: begin
            model_fill = 0;
            owe_result(ST_OK, '0, '0, 0, 1'b1);
         end
      endcase
   endtask

   function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // request driver
   always @(negedge clock) begin : drive
      cmd_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
            c = req_backlog.pop_front();
            req_valid       <= 1'b1;
            req_action      <= c.action;
            req_entry_key   <= c.key;
            req_entry_value <= c.value;
            req_pop_count   <= c.count;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   // beat monitor and result check
   always @(posedge clock) begin : watch
      cmd_type          c;
      stack_result_type want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            model_capacity = csr_wdata;
            csr_beats++;
         end
         if (req_valid && req_ready) begin
            c.action = req_action;
            c.key    = req_entry_key;
            c.value  = req_entry_value;
            c.count  = req_pop_count;
            compute_stack_results(c);
         end
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $error("result beat with nothing outstanding: status %0d", rsp_status);
               errors++;
            end else begin
               want = owed_results.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("out_key", want.key, rsp_out_key);
               check_field("out_value", want.value, rsp_out_value);
               check_field("position", want.position, rsp_position);
               check_field("fill_count", want.fill, rsp_fill_count);
               check_field("last", want.last, rsp_last);
               if (want.last) items_answered++;
            end
         end
      end
   end

   task automatic queue_item(input logic [ACTION_W-1:0] action, input logic [DATA_W-1:0] key,
                             input logic [DATA_W-1:0] value, input logic [COUNT_W-1:0] count);
      cmd_type c;
      c.action = action;
      c.key    = key;
      c.value  = value;
      c.count  = count;
      req_backlog.push_back(c);
      items_queued++;
   endtask

   task automatic queue_random();
      int                  pick;
      logic [ACTION_W-1:0] action;
      logic [DATA_W-1:0]   key;
      logic [DATA_W-1:0]   value;
      logic [COUNT_W-1:0]  count;
      pick = $urandom_range(99);
      if (pick < 30)      action = ACT_PUSH;
      else if (pick < 45) action = ACT_PUSH_UNIQUE;
      else if (pick < 57) action = ACT_POP;
      else if (pick < 66) action = ACT_MULTI_POP;
      else if (pick < 74) action = ACT_PEEK;
      else if (pick < 88) action = ACT_SEARCH;
      else if (pick < 94) action = ACT_REVERSE;
      else                action = ACT_CLEAR;
      // small pools make duplicates and search hits common
      key   = $urandom_range(1) ? key_pool[$urandom_range(3)] : $urandom;
      value = $urandom_range(1) ? value_pool[$urandom_range(3)] : $urandom;
      count = ($urandom_range(3) == 0) ? COUNT_W'($urandom_range(511))
                                       : COUNT_W'($urandom_range(6));
      queue_item(action, key, value, count);
   endtask

   // wait until every queued item has been answered, then let the block go quiet
   task automatic settle(input int extra);
      while (items_answered != items_queued) @(negedge clock);
      repeat (extra) @(negedge clock);
   endtask

   task automatic write_capacity(input logic [COUNT_W-1:0] cap);
      int target;
      settle(8);
      target = csr_beats + 1;
      csr_wdata <= cap;
      csr_valid <= 1'b1;
      while (csr_beats != target) @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [COUNT_W-1:0] cap, input int sender_idle,
                            input int receiver_stall, input int n, input bit pause);
      int i;
      write_capacity(cap);
      sender_idle_pct    = sender_idle;
      receiver_stall_pct = receiver_stall;
      for (i = 0; i < n; i++) begin
         if (pause && i == n / 2) begin
            settle(0);
            @(posedge clock);
         end
         queue_random();
      end
   endtask

   initial begin : stimulus
      int i;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // small capacity: full, duplicate and empty corners
      write_capacity(9'd3);
      queue_item(ACT_PUSH,        32'h8000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_PUSH_UNIQUE, 32'h7fff_ffff, 32'h0000_0000, 9'd511);
      queue_item(ACT_PUSH_UNIQUE, 32'h7fff_ffff, 32'hffff_ffff, 9'd0);
      queue_item(ACT_PUSH,        32'h1234_5678, 32'hffff_ffff, 9'd0);
      queue_item(ACT_PUSH,        32'hffff_ffff, 32'h0000_0001, 9'd0);
      queue_item(ACT_PUSH_UNIQUE, 32'h0000_0000, 32'hffff_ffff, 9'd0);
      queue_item(ACT_PEEK,        32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_SEARCH,      32'h7fff_ffff, 32'hffff_ffff, 9'd0);
      queue_item(ACT_SEARCH,      32'h8000_0000, 32'hffff_ffff, 9'd0);
      queue_item(ACT_REVERSE,     32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_SEARCH,      32'h8000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_POP,         32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_MULTI_POP,   32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_MULTI_POP,   32'h0000_0000, 32'h0000_0000, 9'd511);
      queue_item(ACT_POP,         32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_PEEK,        32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_MULTI_POP,   32'h0000_0000, 32'h0000_0000, 9'd5);
      queue_item(ACT_SEARCH,      32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_REVERSE,     32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_PUSH_UNIQUE, 32'h0000_0005, 32'h0000_0000, 9'd0);
      queue_item(ACT_REVERSE,     32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_CLEAR,       32'hffff_ffff, 32'hffff_ffff, 9'd511);

      // zero capacity refuses every push
      write_capacity(9'd0);
      queue_item(ACT_PUSH,        32'h0000_0001, 32'h0000_0002, 9'd0);
      queue_item(ACT_PUSH_UNIQUE, 32'h0000_0001, 32'h0000_0002, 9'd0);

      // capacity above depth, then lowered below the fill level
      write_capacity(9'd511);
      for (i = 0; i < 5; i++) begin
         queue_item(ACT_PUSH, $urandom, $urandom, COUNT_W'($urandom_range(511)));
      end
      write_capacity(9'd2);
      queue_item(ACT_PUSH,        32'h0000_0009, 32'h0000_0009, 9'd0);
      queue_item(ACT_PUSH_UNIQUE, 32'h0000_0009, 32'h0000_0009, 9'd0);
      queue_item(ACT_MULTI_POP,   32'h0000_0000, 32'h0000_0000, 9'd256);
      queue_item(ACT_CLEAR,       32'h0000_0000, 32'h0000_0000, 9'd0);

      // fill the whole depth, search at both ends, drain by bursts
      write_capacity(9'd256);
      receiver_stall_pct = 64;
      for (i = 0; i < STACK_DEPTH - 1; i++) begin
         queue_item(ACT_PUSH, $urandom, $urandom, COUNT_W'($urandom_range(511)));
      end
      queue_item(ACT_PUSH,        32'h5a5a_a5a5, 32'h0f0f_f0f0, 9'd0);
      queue_item(ACT_SEARCH,      32'h5a5a_a5a5, 32'h0f0f_f0f0, 9'd0);
      queue_item(ACT_PUSH,        32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_PUSH_UNIQUE, 32'h0000_0000, 32'h0f0f_f0f0, 9'd0);
      queue_item(ACT_REVERSE,     32'h0000_0000, 32'h0000_0000, 9'd0);
      queue_item(ACT_SEARCH,      32'h5a5a_a5a5, 32'h0f0f_f0f0, 9'd0);
      queue_item(ACT_PEEK,        32'h0000_0000, 32'h0000_0000, 9'd0);
      for (i = 0; i < 5; i++) queue_item(ACT_MULTI_POP, 32'h0000_0000, 32'h0000_0000, 9'd511);

      run_phase(9'd8, 64, 0, 50, 1'b0);
      run_phase(9'd1, 0, 64, 40, 1'b0);
      run_phase(9'd20, 31, 31, 60, 1'b1);
      run_phase(9'd256, 0, 0, 40, 1'b0);
      run_phase(COUNT_W'($urandom_range(2, 32)), 31, 31, 40, 1'b0);

      settle(20);
      if (owed_results.size() != 0) begin
         $error("%0d expected results never arrived", owed_results.size());
         errors++;
      end
      if (errors == 0) begin
         $display("lifo_stack_with_search_test: done, clean");
      end else begin
         $display("lifo_stack_with_search_test: done, errors");
      end
      $finish;
   end

   initial begin : watchdog
      #20_000_000;
      $display("lifo_stack_with_search_test: done, errors");
      $finish;
   end

endmodule

### filelist.f
rtl/lss_pkg.sv
rtl/lss_front.sv
rtl/lss_queue.sv
rtl/lss_back.sv
rtl/lifo_stack_with_search.sv
verif/lifo_stack_with_search_test.sv
